/* rtl/core/rbcg_pkg.sv */
package rbcg_pkg;

	// configuration register width and register indexes
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_CROP   = 2'd2
	} cfg_idx_t;

	// register values after reset
	localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd1536;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd1232;
	localparam logic [CFG_W-1:0] RST_CROP   = 13'd1232;

	// default geometry
	localparam int OUT_COLS_DEF  = 96;
	localparam int OUT_ROWS_DEF  = 96;
	localparam int MAX_WIDTH_DEF = 4096;

	// luma weights and exact divide by 100 for sums below 43699
	localparam logic [14:0] LUMA_R = 15'd30;
	localparam logic [14:0] LUMA_G = 15'd59;
	localparam logic [14:0] LUMA_B = 15'd11;
	localparam logic [27:0] RECIP_100 = 28'd5243;
	localparam int RECIP_SHIFT = 19;

	// raw10 packing: five bytes carry four pixels, the fifth holds low bits
	localparam logic [2:0] GRP_LAST = 3'd4;

	// sensor width clipped to the supported maximum
	function automatic logic [13:0] eff_width(logic [CFG_W-1:0] w, logic [13:0] maxw);
		logic [13:0] wx;
		wx = {1'b0, w};
		eff_width = (wx > maxw) ? maxw : wx;
	endfunction

	// bytes per packed line, floor(5w/4)
	function automatic logic [13:0] bytes_per_line(logic [13:0] weff);
		bytes_per_line = weff + (weff >> 2);
	endfunction

	// crop offset scaled into the sample accumulator domain: off*2n + n
	function automatic logic [31:0] off_term(logic [13:0] size, logic [CFG_W-1:0] crop,
		logic [9:0] n);
		logic [13:0] cx;
		logic [31:0] off;
		cx = {1'b0, crop};
		off = (size >= cx) ? 32'((size - cx) >> 1) : 32'd0;
		off_term = off * (32'(n) << 1) + 32'(n);
	endfunction

endpackage

/* rtl/core/raw10_bayer_crop_to_gray.sv */
// channel  | signals                              | payload
// ---------+--------------------------------------+----------------------------------------
// s (in)   | s_tvalid s_tready s_tdata s_tuser    | raw10 byte, tuser = frame start
// m (out)  | m_tvalid m_tready m_tdata m_tlast    | gray, column, row; tlast = frame done
// cfg (in) | cfg_valid cfg_ready cfg_index cfg_data | register write, index 0..2
//
// one byte per cycle while the result side keeps up and no register write is pending: input
// register, one compare/update pass, then a luma sum stage and the output register (divide by
// 100 as a reciprocal multiply)
// a register write blocks input while cfg_valid and then resync_q are high; the running
// sample accumulators are rebuilt from the new settings with one multiply each
// arst_n clears counters, pipeline valids and loads the power-on sensor settings
// the line store has no reset; entries are written on the even row before they are read
// output stalls hold the result stages; input keeps flowing until the luma sum stage holds a pixel that cannot move on
module raw10_bayer_crop_to_gray #(
	parameter int OUT_COLS         = rbcg_pkg::OUT_COLS_DEF,
	parameter int OUT_ROWS         = rbcg_pkg::OUT_ROWS_DEF,
	parameter int MAX_SENSOR_WIDTH = rbcg_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,    // [7:0] raw_byte
	input  logic                            s_tuser,    // [0] frame_start
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata,    // [7:0] gray_pixel, [14:8] out_col,
	                                                    // [21:15] out_row, [23:22] zero
	output logic                            m_tlast,    // frame_done
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rbcg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbcg_pkg::CFG_W-1:0]     cfg_data
);
	import rbcg_pkg::*;

	// counter and accumulator widths follow the output grid and maximum line length
	localparam int CKW = $clog2(OUT_COLS + 1);
	localparam int RKW = $clog2(OUT_ROWS + 1);
	localparam int IW  = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1;
	localparam int XW  = $clog2(8 * 8192 * OUT_COLS);
	localparam int YW  = $clog2(8 * 8192 * OUT_ROWS);
	localparam int BPW = $clog2(MAX_SENSOR_WIDTH * 5 / 4 + 1);

	localparam logic [13:0]   MAXW = 14'(MAX_SENSOR_WIDTH);
	localparam logic [XW-1:0] X4N  = XW'(4 * OUT_COLS);
	localparam logic [YW-1:0] Y4N  = YW'(4 * OUT_ROWS);
	localparam logic [9:0]    NC   = 10'(OUT_COLS);
	localparam logic [9:0]    NR   = 10'(OUT_ROWS);

	localparam logic [13:0]   RST_WEFF = eff_width(RST_WIDTH, MAXW);
	localparam logic [BPW-1:0] RST_BPL = BPW'(bytes_per_line(RST_WEFF));
	localparam logic [XW-1:0] RST_OFFX = XW'(off_term(RST_WEFF, RST_CROP, NC));
	localparam logic [YW-1:0] RST_OFFY = YW'(off_term({1'b0, RST_HEIGHT}, RST_CROP, NR));

	// configuration and values derived from it at write time
	logic [CFG_W-1:0] width_q, height_q, crop_q;
	logic [BPW-1:0]   bpl_q;
	logic [XW-1:0]    offx_term_q;
	logic [YW-1:0]    offy_term_q;
	logic [13:0]      crop2;
	logic [13:0]      weff_q, weff_wr;
	logic             cfg_fire, resync_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fs_s1;

	// scan state: byte position, line pair, output grid indexes and sample accumulators.
	// e2/le2 hold the current even pixel/line scaled by 2n, bx/by the next sample
	// position scaled the same way plus the crop offset; a hit is e2 <= bx < e2 + 4n
	logic [BPW-1:0] bc_q;
	logic [2:0]     grp_q;
	logic [XW-1:0]  e2_q;
	logic [11:0]    line_q;
	logic [YW-1:0]  le2_q;
	logic [RKW-1:0] rk_q;
	logic [CKW-1:0] ck_q;
	logic [XW-1:0]  bx_q;
	logic [YW-1:0]  by_q;
	logic [7:0]     glb_q;

	// line store of blue and green bytes from the even row
	logic [7:0] blue_mem_q  [OUT_COLS];
	logic [7:0] green_mem_q [OUT_COLS];
	logic [7:0] rd_b_q, rd_g_q;

	// luma sum stage and output register
	logic        valid_s2;
	logic [14:0] sum_s2;
	logic [6:0]  col_s2, row_s2;
	logic        done_s2;
	logic        out_valid_q;
	logic [7:0]  gray_q;
	logic [6:0]  col_q, row_q;
	logic        last_q;

	// handshake
	logic s_accept, advance, s2_ok, out_ok;

	// current view of the state, with frame start applied
	logic [BPW-1:0] cur_bc;
	logic [2:0]     cur_grp;
	logic [XW-1:0]  cur_e2, cur_bx;
	logic [11:0]    cur_line;
	logic [YW-1:0]  cur_le2, cur_by;
	logic [RKW-1:0] cur_rk;
	logic [CKW-1:0] cur_ck;
	logic [7:0]     cur_glb;
	logic           row_live, col_live, row_hit, col_hit, first_byte, second_byte;
	logic           odd_line, hit_b, hit_g, line_end, emit;
	logic [IW-1:0]  idx;
	logic [7:0]     green_avg;
	logic [14:0]    luma_sum;
	logic           frame_done;

	logic [BPW-1:0] nxt_bc;
	logic [2:0]     nxt_grp;
	logic [XW-1:0]  nxt_e2, nxt_bx;
	logic [11:0]    nxt_line;
	logic [YW-1:0]  nxt_le2, nxt_by;
	logic [RKW-1:0] nxt_rk;
	logic [CKW-1:0] nxt_ck;
	logic [7:0]     nxt_glb;

	logic [XW-1:0] bx_rs;
	logic [YW-1:0] by_rs;
	logic [27:0]   div_prod;

	assign crop2    = {crop_q, 1'b0};
	assign weff_q   = eff_width(width_q, MAXW);
	assign weff_wr  = eff_width(cfg_data, MAXW);
	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;

	// rebuild of the sample accumulators after a register write
	assign bx_rs = offx_term_q + XW'(ck_q) * XW'(crop2);
	assign by_rs = offy_term_q + YW'(rk_q) * YW'(crop2);

	// pipeline control: every byte moves through unless the result side backs up or a register write is pending
	assign out_ok   = !out_valid_q || m_tready;
	assign s2_ok    = !valid_s2 || out_ok;
	assign advance  = valid_s1 && s2_ok && !resync_q && !cfg_valid;
	assign s_tready = (!valid_s1 || advance) && !resync_q && !cfg_valid;
	assign s_accept = s_tvalid && s_tready;

	always_comb begin
		// frame start restarts every counter before the byte is looked at
		cur_bc   = fs_s1 ? '0 : bc_q;
		cur_grp  = fs_s1 ? '0 : grp_q;
		cur_e2   = fs_s1 ? '0 : e2_q;
		cur_line = fs_s1 ? '0 : line_q;
		cur_le2  = fs_s1 ? '0 : le2_q;
		cur_rk   = fs_s1 ? '0 : rk_q;
		cur_ck   = fs_s1 ? '0 : ck_q;
		cur_bx   = fs_s1 ? offx_term_q : bx_q;
		cur_by   = fs_s1 ? offy_term_q : by_q;
		cur_glb  = fs_s1 ? '0 : glb_q;

		row_live    = cur_rk < RKW'(OUT_ROWS);
		col_live    = row_live && (cur_ck < CKW'(OUT_COLS));
		row_hit     = (cur_by >= cur_le2) && (cur_by < cur_le2 + Y4N);
		col_hit     = (cur_bx >= cur_e2) && (cur_bx < cur_e2 + X4N);
		first_byte  = (cur_grp == 3'd0) || (cur_grp == 3'd2);
		second_byte = (cur_grp == 3'd1) || (cur_grp == 3'd3);
		odd_line    = cur_line[0];
		hit_b       = col_live && row_hit && col_hit && first_byte;
		hit_g       = col_live && row_hit && col_hit && second_byte;
		emit        = hit_g && odd_line;
		idx         = cur_ck[IW-1:0];
		line_end    = ((BPW + 1)'(cur_bc) + 1'b1) >= {1'b0, bpl_q};

		// quad: blue and green from the store, second green from this row, red is this byte
		green_avg = 8'(({1'b0, rd_g_q} + {1'b0, cur_glb}) >> 1);
		luma_sum  = LUMA_R * 15'(byte_s1) + LUMA_G * 15'(green_avg) + LUMA_B * 15'(rd_b_q);
		frame_done = (cur_rk == RKW'(OUT_ROWS - 1)) && (cur_ck == CKW'(OUT_COLS - 1));

		nxt_glb = (hit_b && odd_line) ? byte_s1 : cur_glb;
		nxt_ck  = cur_ck;
		nxt_bx  = cur_bx;
		if (hit_g) begin
			nxt_ck = cur_ck + 1'b1;
			nxt_bx = cur_bx + XW'(crop2);
		end
		nxt_rk  = cur_rk;
		nxt_by  = cur_by;
		nxt_le2 = cur_le2;
		if (line_end) begin
			nxt_bc   = '0;
			nxt_grp  = '0;
			nxt_e2   = '0;
			nxt_ck   = '0;
			nxt_bx   = offx_term_q;
			nxt_line = cur_line + 1'b1;
			if (odd_line) begin
				// next line opens a new pair; the line counter wraps at 4096
				nxt_le2 = (cur_line == 12'hFFF) ? '0 : cur_le2 + Y4N;
				if (row_live && row_hit) begin
					nxt_rk = cur_rk + 1'b1;
					nxt_by = cur_by + YW'(crop2);
				end
			end
		end else begin
			nxt_bc   = cur_bc + 1'b1;
			nxt_grp  = (cur_grp == GRP_LAST) ? 3'd0 : cur_grp + 1'b1;
			nxt_e2   = ((cur_grp == 3'd1) || (cur_grp == GRP_LAST)) ? cur_e2 + X4N : cur_e2;
			nxt_line = cur_line;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= RST_WIDTH;
			height_q    <= RST_HEIGHT;
			crop_q      <= RST_CROP;
			bpl_q       <= RST_BPL;
			offx_term_q <= RST_OFFX;
			offy_term_q <= RST_OFFY;
			resync_q    <= 1'b0;
		end else begin
			resync_q <= cfg_fire;
			if (cfg_fire) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_WIDTH: begin
						width_q     <= cfg_data;
						bpl_q       <= BPW'(bytes_per_line(weff_wr));
						offx_term_q <= XW'(off_term(weff_wr, crop_q, NC));
					end
					CFG_HEIGHT: begin
						height_q    <= cfg_data;
						offy_term_q <= YW'(off_term({1'b0, cfg_data}, crop_q, NR));
					end
					CFG_CROP: begin
						crop_q      <= cfg_data;
						offx_term_q <= XW'(off_term(weff_q, cfg_data, NC));
						offy_term_q <= YW'(off_term({1'b0, height_q}, cfg_data, NR));
					end
					default: begin
					end
				endcase
			end
		end
	end

	// input register and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			bc_q     <= '0;
			grp_q    <= '0;
			e2_q     <= '0;
			line_q   <= '0;
			le2_q    <= '0;
			rk_q     <= '0;
			ck_q     <= '0;
			bx_q     <= RST_OFFX;
			by_q     <= RST_OFFY;
			glb_q    <= '0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				bc_q   <= nxt_bc;
				grp_q  <= nxt_grp;
				e2_q   <= nxt_e2;
				line_q <= nxt_line;
				le2_q  <= nxt_le2;
				rk_q   <= nxt_rk;
				ck_q   <= nxt_ck;
				bx_q   <= nxt_bx;
				by_q   <= nxt_by;
				glb_q  <= nxt_glb;
			end else if (resync_q) begin
				bx_q <= bx_rs;
				by_q <= by_rs;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			byte_s1 <= s_tdata;
			fs_s1   <= s_tuser;
		end
	end

	// line store: blue byte then green byte on the even row, read back one byte
	// ahead of the red byte on the odd row
	always_ff @(posedge clk) begin
		if (advance && hit_b && !odd_line) begin
			blue_mem_q[idx] <= byte_s1;
		end
		if (advance && hit_g && !odd_line) begin
			green_mem_q[idx] <= byte_s1;
		end
		if (advance && hit_b && odd_line) begin
			rd_b_q <= blue_mem_q[idx];
			rd_g_q <= green_mem_q[idx];
		end
	end

	// result stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_ok) begin
				valid_s2 <= advance && emit;
			end
			if (out_ok) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	assign div_prod = 28'(sum_s2) * RECIP_100;

	always_ff @(posedge clk) begin
		if (s2_ok && advance && emit) begin
			sum_s2  <= luma_sum;
			col_s2  <= 7'(cur_ck);
			row_s2  <= 7'(cur_rk);
			done_s2 <= frame_done;
		end
		if (out_ok && valid_s2) begin
			// gray minus 128 is the top bit flipped
			gray_q <= div_prod[RECIP_SHIFT+7:RECIP_SHIFT] ^ 8'h80;
			col_q  <= col_s2;
			row_q  <= row_s2;
			last_q <= done_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, row_q, col_q, gray_q};
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	// column index never runs past the end of the output row
	assert property (@(posedge clk) disable iff (!arst_n) ck_q <= CKW'(OUT_COLS))
		else $error("output column index out of range");

	// row index never runs past the output row count
	assert property (@(posedge clk) disable iff (!arst_n) rk_q <= RKW'(OUT_ROWS))
		else $error("output row index out of range");

	// group position and even pixel accumulator restart together with the byte column
	assert property (@(posedge clk) disable iff (!arst_n)
		(bc_q == '0) |-> ((grp_q == 3'd0) && (e2_q == '0)))
		else $error("byte position state out of step at line start");

	// a pixel enters the sum stage only from a processed byte
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(advance))
		else $error("result without a processed byte");
`endif

endmodule
